// ----- sv/egcd_pkg.sv -----
package egcd_pkg;

	// fixed field widths of the stream beats
	localparam int COEF_W     = 64;
	localparam int DIV_W      = 63;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 192;

	// status of the euclid sequencer as seen by the wrapper
	typedef struct packed {
		logic busy;  // an item is in the core, including a finished one not yet taken
		logic done;  // result is held and waits for ack
	} egcd_stat_t;

endpackage

// ----- sv/egcd_core.sv -----
module egcd_core import egcd_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDTH-1:0]  op_big,
	input  logic [WIDTH-1:0]  op_sml,
	input  logic              ack,
	output egcd_stat_t        stat,
	output logic [WIDTH-1:0]  gcd,
	output logic [COEF_W-1:0] coef_u,
	output logic [COEF_W-1:0] coef_v
);

	localparam int CNT_W = $clog2(WIDTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UP   = 3'd1;
	localparam logic [2:0] ST_DOWN = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  j_q;
	logic [WIDTH-1:0]  r0_q, r1_q, rem_q, dv_q;
	logic [COEF_W-1:0] s0_q, s1_q, t0_q, t1_q, acc_s_q, acc_t_q;

	logic [WIDTH-1:0]  cmp_op;
	logic [WIDTH:0]    diff;
	logic              ge;

	// shared compare/subtract: against 2*divisor while scaling up, divisor while stepping down
	assign cmp_op = (state_q == ST_UP) ? {dv_q[WIDTH-2:0], 1'b0} : dv_q;
	assign diff   = {1'b0, rem_q} - {1'b0, cmp_op};
	assign ge     = ~diff[WIDTH];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						j_q     <= '0;
						state_q <= (op_sml == '0) ? ST_DONE : ST_UP;
					end
				end
				ST_UP: begin
					if (!dv_q[WIDTH-1] && ge) begin
						j_q <= j_q + CNT_W'(1);
					end else begin
						state_q <= ST_DOWN;
					end
				end
				ST_DOWN: begin
					if (j_q == '0) begin
						state_q <= ST_UPD;
					end else begin
						j_q <= j_q - CNT_W'(1);
					end
				end
				ST_UPD: begin
					j_q     <= '0;
					state_q <= (rem_q == '0) ? ST_DONE : ST_UP;
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					r0_q    <= op_big;
					r1_q    <= op_sml;
					rem_q   <= op_big;
					dv_q    <= op_sml;
					s0_q    <= COEF_W'(1);
					s1_q    <= '0;
					t0_q    <= '0;
					t1_q    <= COEF_W'(1);
					acc_s_q <= '0;
					acc_t_q <= '0;
				end
			end
			ST_UP: begin
				if (!dv_q[WIDTH-1] && ge) begin
					dv_q <= {dv_q[WIDTH-2:0], 1'b0};
				end
			end
			ST_DOWN: begin
				// quotient bit msb first; q*s1 and q*t1 built horner style
				if (ge) begin
					rem_q <= diff[WIDTH-1:0];
				end
				acc_s_q <= {acc_s_q[COEF_W-2:0], 1'b0} + (ge ? s1_q : '0);
				acc_t_q <= {acc_t_q[COEF_W-2:0], 1'b0} + (ge ? t1_q : '0);
				dv_q    <= {1'b0, dv_q[WIDTH-1:1]};
			end
			ST_UPD: begin
				r0_q    <= r1_q;
				r1_q    <= rem_q;
				rem_q   <= r1_q;
				dv_q    <= rem_q;
				s0_q    <= s1_q;
				s1_q    <= s0_q - acc_s_q;
				t0_q    <= t1_q;
				t1_q    <= t0_q - acc_t_q;
				acc_s_q <= '0;
				acc_t_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign gcd       = r0_q;
	assign coef_u    = s0_q;
	assign coef_v    = t0_q;

	// a finished result always has a zero remainder behind it
	a_done_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> r1_q == '0)
		else $error("result raised with nonzero remainder");

	// the last down step sees the unscaled divisor again
	a_down_realigned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOWN && j_q == '0) |-> dv_q == r1_q)
		else $error("divisor not realigned at last quotient bit");

	// remainder of a step stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> rem_q < r1_q)
		else $error("remainder not reduced below divisor");

	// a new item only starts on an idle core
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("start while core busy");

endmodule

// ----- sv/extended_gcd_unit.sv -----
// extended euclid unit: gcd and bezout coefficients of two signed operands
//
// input channel s_axis: one beat carries operand_a and operand_b; the low WIDTH
// bits of each are used, sign-extended from bit WIDTH-1
// output channel m_axis: one beat per input beat with coeff_x, coeff_y and
// divisor_d, where operand_a*coeff_x + operand_b*coeff_y = divisor_d
// both operands zero give d=0, x=1, y=0; a gcd of 2^63 saturates d to 2^63-1
//
// timing: one item is in the core at a time and s_axis_tready is low meanwhile.
// each euclid step scales the divisor up k times, k being the bit length of its quotient
// minus one, then shifts it back down and takes a quotient bit at each position by
// shift-subtract on the one shared subtractor; fibonacci-like operands give the most
// euclid steps
//
// reset clears the sequencer and the output valid; no state is kept between items.
// a finished result sits in the output register; when the receiver stalls the
// next item may already be accepted and computed, and it waits in the core
// until the output register frees up
module extended_gcd_unit import egcd_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // operand_a [63:0], operand_b [127:64]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // coeff_x [63:0], coeff_y [127:64],
	                                              // divisor_d [190:128], zero [191]
);

	egcd_stat_t        core_stat;
	logic              start;
	logic              load;
	logic [WIDTH-1:0]  va, vb, ma, mb;
	logic              neg_a, neg_b, swap;
	logic [WIDTH-1:0]  gcd;
	logic [COEF_W-1:0] coef_u, coef_v;
	logic [COEF_W-1:0] x_raw, y_raw, x_fin, y_fin, d_ext;
	logic [DIV_W-1:0]  d_fin;

	// sign flags and exchange of the item in the core
	logic              neg_a_q, neg_b_q, swap_q;
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	assign s_axis_tready = ~core_stat.busy;
	assign start         = s_axis_tvalid & s_axis_tready;

	// magnitudes; the most negative value maps to 2^(WIDTH-1), still exact unsigned
	assign va    = s_axis_tdata[WIDTH-1:0];
	assign vb    = s_axis_tdata[COEF_W+WIDTH-1:COEF_W];
	assign neg_a = va[WIDTH-1];
	assign neg_b = vb[WIDTH-1];
	assign ma    = neg_a ? ('0 - va) : va;
	assign mb    = neg_b ? ('0 - vb) : vb;
	assign swap  = (ma < mb);

	always_ff @(posedge clk) begin
		if (start) begin
			neg_a_q <= neg_a;
			neg_b_q <= neg_b;
			swap_q  <= swap;
		end
	end

	egcd_core #(.WIDTH(WIDTH)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op_big (swap ? mb : ma),
		.op_sml (swap ? ma : mb),
		.ack    (load),
		.stat   (core_stat),
		.gcd    (gcd),
		.coef_u (coef_u),
		.coef_v (coef_v)
	);

	// undo the exchange and the sign folding
	assign x_raw = swap_q ? coef_v : coef_u;
	assign y_raw = swap_q ? coef_u : coef_v;
	assign x_fin = neg_a_q ? ('0 - x_raw) : x_raw;
	assign y_fin = neg_b_q ? ('0 - y_raw) : y_raw;
	assign d_ext = COEF_W'(gcd);
	assign d_fin = d_ext[COEF_W-1] ? '1 : d_ext[DIV_W-1:0];

	// output register: takes the core result whenever it is empty or draining
	assign load = core_stat.done & (~m_valid_q | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_data_q <= {1'b0, d_fin, y_fin, x_fin};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ----- sim/egcd_checker.sv -----
module egcd_checker import egcd_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    fail_count,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [COEF_W-1:0] D_SAT = {1'b0, {(COEF_W-1){1'b1}}};

	typedef struct packed {
		logic [COEF_W-1:0] op_a;
		logic [COEF_W-1:0] op_b;
		logic [COEF_W-1:0] x;
		logic [COEF_W-1:0] y;
		logic [DIV_W-1:0]  d;
	} bezout_t;

	bezout_t expected_bezout[$];

	// gcd and bezout pair of two operands, coefficients kept modulo 2^64
	function automatic bezout_t predict_bezout(logic [COEF_W-1:0] a_in,
			logic [COEF_W-1:0] b_in);
		logic [COEF_W-1:0] mag_a, mag_b, r0, r1, r2, s0, s1, s2, t0, t1, t2, q;
		logic              neg_a, neg_b, swapped;
		bezout_t           res;
		mag_a = $signed(a_in << (COEF_W - WIDTH)) >>> (COEF_W - WIDTH);
		mag_b = $signed(b_in << (COEF_W - WIDTH)) >>> (COEF_W - WIDTH);
		neg_a = mag_a[COEF_W-1];
		neg_b = mag_b[COEF_W-1];
		if (neg_a) mag_a = -mag_a;
		if (neg_b) mag_b = -mag_b;
		swapped = mag_a < mag_b;
		r0 = swapped ? mag_b : mag_a;
		r1 = swapped ? mag_a : mag_b;
		s0 = COEF_W'(1);
		s1 = '0;
		t0 = '0;
		t1 = COEF_W'(1);
		while (r1 != 0) begin
			q  = r0 / r1;
			r2 = r0 % r1;
			s2 = s0 - q * s1;
			t2 = t0 - q * t1;
			r0 = r1;
			r1 = r2;
			s0 = s1;
			s1 = s2;
			t0 = t1;
			t1 = t2;
		end
		res.op_a = a_in;
		res.op_b = b_in;
		res.x    = swapped ? t0 : s0;
		res.y    = swapped ? s0 : t0;
		if (neg_a) res.x = -res.x;
		if (neg_b) res.y = -res.y;
		res.d = (r0 > D_SAT) ? D_SAT[DIV_W-1:0] : r0[DIV_W-1:0];
		return res;
	endfunction

	function automatic void check_field(string name, bezout_t want, logic [COEF_W-1:0] exp_v,
			logic [COEF_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t ns: %s for a=%h b=%h: expected %h actual %h",
				$time, name, want.op_a, want.op_b, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		bezout_t want;
		if (!arst_n) begin
			expected_bezout.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			// result side first, so a result never matches an item taken in the same cycle
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bezout.size() == 0) begin
					$display("%0t ns: result beat with nothing expected: expected none actual %h",
						$time, m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_bezout.pop_front();
					check_field("coeff_x", want, want.x, m_axis_tdata[COEF_W-1:0]);
					check_field("coeff_y", want, want.y, m_axis_tdata[2*COEF_W-1:COEF_W]);
					check_field("divisor_d", want, {1'b0, want.d},
						{1'b0, m_axis_tdata[2*COEF_W+DIV_W-1:2*COEF_W]});
					check_field("pad bit", want, '0, {63'd0, m_axis_tdata[OUT_DATA_W-1]});
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_bezout.push_back(predict_bezout(s_axis_tdata[COEF_W-1:0],
					s_axis_tdata[2*COEF_W-1:COEF_W]));
			outstanding = expected_bezout.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import egcd_pkg::*;

	localparam int          WIDTH     = 64;
	localparam int          N_RANDOM  = 1180;
	localparam logic [63:0] MOST_NEG  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MOST_POS  = 64'h7fff_ffff_ffff_ffff;
	localparam int          DRAIN_CYC = 320;  // a bit more than one worst-case item

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // operand_a [63:0], operand_b [127:64]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // coeff_x [63:0], coeff_y [127:64],
	                                       // divisor_d [190:128], zero [191]
	int                    fail_count;
	int                    outstanding;
	bit                    steady;         // no idling on either side while set

	extended_gcd_unit #(.WIDTH(WIDTH)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	egcd_checker #(.WIDTH(WIDTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver stalls with a chance of about 7 in a hundred, except in the steady window
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 7);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] with_rand_sign(logic [63:0] v);
		return $urandom_range(1) ? -v : v;
	endfunction

	// consecutive fibonacci numbers, the slowest case for euclid
	function automatic void fib_pair(int n, output logic [63:0] hi, output logic [63:0] lo);
		logic [63:0] nxt;
		lo = 64'd0;
		hi = 64'd1;
		repeat (n) begin
			nxt = lo + hi;
			lo  = hi;
			hi  = nxt;
		end
	endfunction

	// one operand beat, with a random number of idle cycles ahead of it
	task automatic send_operands(logic [63:0] a, logic [63:0] b);
		while (!steady && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin
		logic [63:0] a, b, g, fa, fb;
		int          kind, n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		steady        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zeros, one zero, equal magnitudes, most negative value, extremes
		send_operands(64'd0, 64'd0);
		send_operands(64'd0, 64'd5);
		send_operands(-64'd7, 64'd0);
		send_operands(64'd0, -MOST_POS);
		send_operands(64'd12, 64'd12);
		send_operands(-64'd12, 64'd12);
		send_operands(64'd12, -64'd12);
		send_operands(-64'd9, -64'd9);
		send_operands(MOST_NEG, 64'd0);
		send_operands(64'd0, MOST_NEG);
		send_operands(MOST_NEG, MOST_NEG);   // gcd of 2^63 saturates
		send_operands(MOST_NEG, 64'd6);
		send_operands(MOST_POS, MOST_NEG);
		send_operands(MOST_POS, MOST_POS);
		send_operands(-MOST_POS, 64'd1);
		send_operands(64'd1, -64'd1);
		send_operands(64'd240, 64'd46);
		send_operands(-64'd35, -64'd15);
		send_operands(64'd3, 64'd7);
		fib_pair(91, fa, fb);
		send_operands(fa, fb);
		send_operands(-fb, fa);
		send_operands(64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555);

		// random part, mostly small or structured operands to keep the run short
		for (int i = 0; i < N_RANDOM; i++) begin
			steady = (i >= 500) && (i < 700);
			kind   = $urandom_range(99);
			if (kind < 30) begin
				a = rand64();
				b = rand64();
			end else if (kind < 55) begin
				a = with_rand_sign(64'($urandom_range(1000)));
				b = with_rand_sign(64'($urandom_range(1000)));
			end else if (kind < 75) begin
				// shared factor so the gcd is not mostly one
				g = 64'($urandom_range(1, 1 << 20));
				a = with_rand_sign(g * 64'($urandom_range(1 << 20)));
				b = with_rand_sign(g * 64'($urandom_range(1 << 20)));
			end else if (kind < 85) begin
				n = $urandom_range(1, 91);
				fib_pair(n, fa, fb);
				a = with_rand_sign($urandom_range(1) ? fa : fb);
				b = with_rand_sign((a == fa || a == -fa) ? fb : fa);
			end else if (kind < 90) begin
				// one operand zero, or equal magnitudes
				a = rand64();
				case ($urandom_range(2))
					0: b = 64'd0;
					1: b = with_rand_sign(a);
					default: begin
						b = a;
						a = 64'd0;
					end
				endcase
			end else begin
				n = $urandom_range(1, 63);
				a = with_rand_sign(rand64() & ((64'd1 << n) - 64'd1));
				n = $urandom_range(1, 63);
				b = with_rand_sign(rand64() & ((64'd1 << n) - 64'd1));
			end
			send_operands(a, b);
		end
		s_axis_tvalid <= 1'b0;
		steady = 1'b0;

		// drain, then watch a while longer for stray result beats
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("extended_gcd_unit: match");
		end else begin
			$display("extended_gcd_unit: mismatch");
		end
		$finish;
	end

	// timeout, several times the slowest correct run
	initial begin
		#5_000_000;
		$display("extended_gcd_unit: mismatch");
		$finish;
	end

endmodule
